// ===== rtl/mmbsc_pkg.sv =====
// Shared types, codes and constants for the multi-mode byte stream cipher.
// Used by mmbsc_rc4 and the top level; depends on nothing else.
`timescale 1ns / 1ps

package mmbsc_pkg;

  localparam int unsigned SBOX_DEPTH = 256;

  // Mode codes; unused codes behave as passthrough
  localparam logic [2:0] MODE_PASS     = 3'd0;
  localparam logic [2:0] MODE_CAESAR   = 3'd1;
  localparam logic [2:0] MODE_XOR      = 3'd2;
  localparam logic [2:0] MODE_VIGENERE = 3'd3;
  localparam logic [2:0] MODE_RC4      = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_SHIFT    = 3'd1;
  localparam logic [2:0] CFG_XOR_KEY  = 3'd2;
  localparam logic [2:0] CFG_VIG_KEY  = 3'd3;
  localparam logic [2:0] CFG_RC4_LOW  = 3'd4;
  localparam logic [2:0] CFG_RC4_HIGH = 3'd5;

  localparam logic [2:0]  RST_MODE     = MODE_PASS;
  localparam logic [6:0]  RST_SHIFT    = 7'd3;
  localparam logic [31:0] RST_XOR_KEY  = 32'h3433_3231;            // "1234"
  localparam logic [39:0] RST_VIG_KEY  = 40'h45_4E4A_4154;         // "TAJNE"
  localparam logic [63:0] RST_RC4_LOW  = 64'h3837_3635_3433_3231;  // "12345678"
  localparam logic [63:0] RST_RC4_HIGH = 64'h3635_3433_3231_3039;  // "90123456"

  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam logic [7:0] PRINT_SPAN = 8'd95;

  typedef struct packed {
    logic start;
    logic sched;
  } rc4_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] ks;
  } rc4_rsp_t;

  // Shift register value reduced mod 95; input is below 128
  function automatic logic [6:0] reduce_shift(input logic [6:0] s);
    logic [6:0] r;
    r = (s >= PRINT_SPAN[6:0]) ? s - PRINT_SPAN[6:0] : s;
    return r;
  endfunction

  // (kc - 32) mod 95 as a non-negative residue, taken as (kc + 63) mod 95
  function automatic logic [6:0] vig_shift(input logic [7:0] kc);
    logic [8:0] v;
    v = {1'b0, kc} + 9'd63;
    if (v >= 9'd285) begin
      v = v - 9'd285;
    end else if (v >= 9'd190) begin
      v = v - 9'd190;
    end else if (v >= 9'd95) begin
      v = v - 9'd95;
    end
    return v[6:0];
  endfunction

  // Shift within printable ASCII; s is already below 95
  function automatic logic [7:0] shift_printable(input logic [7:0] c, input logic [6:0] s);
    logic [7:0] off;
    logic [7:0] r;
    off = (c - PRINT_LO) + {1'b0, s};
    if (off >= PRINT_SPAN) begin
      off = off - PRINT_SPAN;
    end
    r = (c inside {[PRINT_LO:PRINT_HI]}) ? off + PRINT_LO : c;
    return r;
  endfunction

endpackage

// ===== rtl/mmbsc_rc4.sv =====
// RC4 engine: permutation table in a one-read, one-write synchronous memory,
// key schedule sequencer and keystream generator. Depends on mmbsc_pkg.
`timescale 1ns / 1ps

module mmbsc_rc4 import mmbsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rc4_req_t     req_i,
  input  logic [127:0] key_i,
  output rc4_rsp_t     rsp_o
);

  localparam logic [3:0] E_IDLE = 4'd0;
  localparam logic [3:0] E_INIT = 4'd1;
  localparam logic [3:0] E_KA   = 4'd2;
  localparam logic [3:0] E_KB   = 4'd3;
  localparam logic [3:0] E_KC   = 4'd4;
  localparam logic [3:0] E_KD   = 4'd5;
  localparam logic [3:0] E_PA   = 4'd6;
  localparam logic [3:0] E_PB   = 4'd7;
  localparam logic [3:0] E_PC   = 4'd8;
  localparam logic [3:0] E_PD   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [7:0] n_q, n_d;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic [7:0] sa_q, sa_d;   // S[i] or S[n]
  logic [7:0] sb_q, sb_d;   // S[j]
  logic [7:0] t_q, t_d;

  logic [7:0] sbox_q [SBOX_DEPTH];
  logic [7:0] rd_q;
  logic       we;
  logic [7:0] wa;
  logic [7:0] wd;
  logic [7:0] ra;

  logic [7:0] key_byte;
  logic [7:0] j_step;
  logic [7:0] t_sum;

  assign key_byte = key_i[{n_q[3:0], 3'b000} +: 8];
  assign j_step   = j_q + rd_q + ((state_q == E_KB) ? key_byte : 8'd0);
  assign t_sum    = sa_q + rd_q;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    t_d     = t_q;
    we      = 1'b0;
    wa      = n_q;
    wd      = n_q;
    ra      = i_q + 8'd1;
    case (state_q)
      E_IDLE: begin
        if (req_i.start) begin
          if (req_i.sched) begin
            n_d     = 8'd0;
            state_d = E_INIT;
          end else begin
            // read of S[i+1] already issued this cycle
            i_d     = i_q + 8'd1;
            state_d = E_PB;
          end
        end
      end
      E_INIT: begin
        we  = 1'b1;
        n_d = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          j_d     = 8'd0;
          state_d = E_KA;
        end
      end
      E_KA: begin
        ra      = n_q;
        state_d = E_KB;
      end
      E_KB: begin
        sa_d    = rd_q;
        j_d     = j_step;
        ra      = j_step;
        state_d = E_KC;
      end
      E_KC: begin
        we      = 1'b1;
        wa      = n_q;
        wd      = rd_q;
        state_d = E_KD;
      end
      E_KD: begin
        we  = 1'b1;
        wa  = j_q;
        wd  = sa_q;
        n_d = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          i_d     = 8'd0;
          j_d     = 8'd0;
          state_d = E_PA;
        end else begin
          state_d = E_KA;
        end
      end
      E_PA: begin
        i_d     = i_q + 8'd1;
        state_d = E_PB;
      end
      E_PB: begin
        sa_d    = rd_q;
        j_d     = j_step;
        ra      = j_step;
        state_d = E_PC;
      end
      E_PC: begin
        sb_d    = rd_q;
        t_d     = t_sum;
        ra      = t_sum;
        we      = 1'b1;
        wa      = i_q;
        wd      = rd_q;
        state_d = E_PD;
      end
      E_PD: begin
        we      = 1'b1;
        wa      = j_q;
        wd      = sa_q;
        state_d = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
  end

  // read of S[t] overlapped the swap writes: forward the swapped values
  assign rsp_o.done = (state_q == E_PD);
  assign rsp_o.ks   = (t_q == j_q) ? sa_q :
                      (t_q == i_q) ? sb_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      sbox_q[wa] <= wd;
    end
    rd_q <= sbox_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      n_q     <= 8'd0;
      i_q     <= 8'd0;
      j_q     <= 8'd0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q <= sa_d;
    sb_q <= sb_d;
    t_q  <= t_d;
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == E_IDLE)
    else $error("rc4 start while engine busy");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> state_q == E_IDLE)
    else $error("rc4 engine did not return to idle after a byte");

  a_sched_clears_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_KD && n_q == 8'hFF) |=> (state_q == E_PA && i_q == 8'd0 && j_q == 8'd0))
    else $error("key schedule did not clear indices");

endmodule

// ===== rtl/multi_mode_byte_stream_cipher.sv =====
// Caesar, xor, vigenere and passthrough bytes load the output register on acceptance, or a
// result register while the output stalls; one byte per cycle while it does not stall. An
// rc4 byte holds off further input until its keystream byte is ready: the S[i], S[j] and
// S[S[i]+S[j]] reads chain through the one-read, one-write permutation memory. An rc4 message
// start first runs the key schedule, a table fill and 256 swaps, then reissues the S[i] read.
// Reset clears indices and key positions and loads the register defaults; the permutation
// table is undefined until the first rc4 message start. Depends on mmbsc_pkg and mmbsc_rc4.
`timescale 1ns / 1ps

module multi_mode_byte_stream_cipher import mmbsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_message_i,
  input  logic        last_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cipher_byte_o,
  output logic        end_of_message_o
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_WAIT = 2'd1;
  localparam logic [1:0] T_OUT  = 2'd2;

  logic [2:0]  mode_q;
  logic [6:0]  shift_q;
  logic [31:0] xor_key_q;
  logic [39:0] vig_key_q;
  logic [63:0] rc4_low_q;
  logic [63:0] rc4_high_q;

  logic [1:0] state_q, state_d;
  logic [1:0] xor_pos_q, xor_pos_d;
  logic [2:0] vig_pos_q, vig_pos_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic [7:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] cipher_q, cipher_d;
  logic       eom_q, eom_d;

  logic       in_acc;
  logic       out_free;
  logic       load;
  logic [1:0] xpos;
  logic [2:0] vpos;
  logic [7:0] vig_char;
  logic [7:0] classic;
  logic [7:0] rc4_byte;

  rc4_req_t rc4_req;
  rc4_rsp_t rc4_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != T_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign cipher_byte_o    = cipher_q;
  assign end_of_message_o = eom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= RST_MODE;
      shift_q    <= RST_SHIFT;
      xor_key_q  <= RST_XOR_KEY;
      vig_key_q  <= RST_VIG_KEY;
      rc4_low_q  <= RST_RC4_LOW;
      rc4_high_q <= RST_RC4_HIGH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:     mode_q     <= cfg_data_i[2:0];
        CFG_SHIFT:    shift_q    <= cfg_data_i[6:0];
        CFG_XOR_KEY:  xor_key_q  <= cfg_data_i[31:0];
        CFG_VIG_KEY:  vig_key_q  <= cfg_data_i[39:0];
        CFG_RC4_LOW:  rc4_low_q  <= cfg_data_i;
        CFG_RC4_HIGH: rc4_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Key positions restart on a message start
  assign xpos = first_of_message_i ? 2'd0 : xor_pos_q;
  assign vpos = first_of_message_i ? 3'd0 : vig_pos_q;

  always_comb begin
    case (vpos)
      3'd0:    vig_char = vig_key_q[7:0];
      3'd1:    vig_char = vig_key_q[15:8];
      3'd2:    vig_char = vig_key_q[23:16];
      3'd3:    vig_char = vig_key_q[31:24];
      3'd4:    vig_char = vig_key_q[39:32];
      default: vig_char = 8'd0;
    endcase
  end

  always_comb begin
    case (mode_q)
      MODE_CAESAR:   classic = shift_printable(data_byte_i, reduce_shift(shift_q));
      MODE_XOR:      classic = data_byte_i ^ xor_key_q[{xpos, 3'b000} +: 8];
      MODE_VIGENERE: classic = shift_printable(data_byte_i, vig_shift(vig_char));
      default:       classic = data_byte_i;
    endcase
  end

  assign rc4_req.start = in_acc && (mode_q == MODE_RC4);
  assign rc4_req.sched = first_of_message_i;

  mmbsc_rc4 u_rc4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rc4_req),
    .key_i  ({rc4_high_q, rc4_low_q}),
    .rsp_o  (rc4_rsp)
  );

  assign rc4_byte = data_q ^ rc4_rsp.ks;

  always_comb begin
    state_d   = state_q;
    xor_pos_d = xor_pos_q;
    vig_pos_d = vig_pos_q;
    data_d    = data_q;
    last_d    = last_q;
    res_d     = res_q;
    load      = 1'b0;
    cipher_d  = cipher_q;
    eom_d     = eom_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          data_d    = data_byte_i;
          last_d    = last_of_message_i;
          xor_pos_d = xpos + 2'd1;
          vig_pos_d = (vpos == 3'd4) ? 3'd0 : vpos + 3'd1;
          if (mode_q == MODE_RC4) begin
            state_d = T_WAIT;
          end else if (out_free) begin
            load     = 1'b1;
            cipher_d = classic;
            eom_d    = last_of_message_i;
          end else begin
            res_d   = classic;
            state_d = T_OUT;
          end
        end
      end
      T_WAIT: begin
        if (rc4_rsp.done) begin
          if (out_free) begin
            load     = 1'b1;
            cipher_d = rc4_byte;
            eom_d    = last_q;
            state_d  = T_IDLE;
          end else begin
            res_d   = rc4_byte;
            state_d = T_OUT;
          end
        end
      end
      T_OUT: begin
        if (out_free) begin
          load     = 1'b1;
          cipher_d = res_q;
          eom_d    = last_q;
          state_d  = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      xor_pos_q   <= 2'd0;
      vig_pos_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      xor_pos_q   <= xor_pos_d;
      vig_pos_q   <= vig_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    last_q   <= last_d;
    res_q    <= res_d;
    cipher_q <= cipher_d;
    eom_q    <= eom_d;
  end

  a_out_state_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_OUT |-> out_valid_q)
    else $error("parked result while output register empty");

  a_rc4_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q == MODE_RC4) |=> (state_q == T_WAIT && in_stall_o))
    else $error("rc4 beat accepted without waiting for engine");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc4_rsp.done |-> state_q == T_WAIT)
    else $error("keystream byte with no rc4 beat pending");

  a_vig_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vig_pos_q <= 3'd4)
    else $error("vigenere position out of range");

endmodule
